>>> src/chtt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtt_pkg
// Shared types, widths and codes for the coalesced hash translation table.
// ----------------------------------------------------------------------------
package chtt_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 32;
  localparam int CODE_W     = 32;
  localparam int TAG_W      = 4;
  localparam int OP_W       = 2;
  localparam int BUCKET_W   = 10;
  localparam int STAT_W     = 3;

  // operations
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_SUSPENDED = 3'd4;

  // table read selects
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_HOME  = 2'd1;
  localparam logic [1:0] RD_CHAIN = 2'd2;
  localparam logic [1:0] RD_PROBE = 2'd3;

  // table write selects
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_CLEAR = 2'd1;
  localparam logic [1:0] WR_UPD   = 2'd2;
  localparam logic [1:0] WR_LINK  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    key_pc;
    logic [BUCKET_W-1:0] bucket;
    logic [CODE_W-1:0]   new_code_address;
    logic [TAG_W-1:0]    new_isa_tag;
    logic                threads_suspended;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot_index;
    logic [CODE_W-1:0] code_address;
    logic [TAG_W-1:0]  isa_tag;
    logic [CNT_W-1:0]  used_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  next;
    logic [CODE_W-1:0] code;
    logic [TAG_W-1:0]  isa;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic              latch;
    logic [1:0]        rd;
    logic              save_prev;
    logic [1:0]        wr;
    logic              clr_step;
    logic              finish;
    logic [STAT_W-1:0] fin_status;
    logic              fin_add;
  } cmd_t;

  typedef struct packed {
    logic            key_zero;
    logic [OP_W-1:0] op;
    logic            susp;
    logic            match;
    logic            at_end;
    logic            slot_empty;
    logic            probe_full;
    logic            clr_last;
  } sts_t;

endpackage

>>> src/chtt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module chtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/chtt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtt_ctrl
// Sequencer: clearing pass, decode, chain walk, free-slot probe and link.
// ----------------------------------------------------------------------------
module chtt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  chtt_pkg::sts_t sts,
  output chtt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_LINK   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.wr       = chtt_pkg::WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.key_zero || !(sts.op == chtt_pkg::OP_LOOKUP || sts.op == chtt_pkg::OP_ADD ||
                              sts.op == chtt_pkg::OP_SET)) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = chtt_pkg::ST_NOT_FOUND;
          state_next     = S_IDLE;
        end else if (sts.op == chtt_pkg::OP_LOOKUP && sts.susp) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = chtt_pkg::ST_SUSPENDED;
          state_next     = S_IDLE;
        end else begin
          cmd.rd     = chtt_pkg::RD_HOME;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.match) begin
          if (sts.op == chtt_pkg::OP_SET) begin
            cmd.wr = chtt_pkg::WR_UPD;
          end
          cmd.finish     = 1'b1;
          cmd.fin_status = chtt_pkg::ST_FOUND;
          state_next     = S_IDLE;
        end else if (sts.at_end) begin
          if (sts.op == chtt_pkg::OP_LOOKUP) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = chtt_pkg::ST_NOT_FOUND;
            state_next     = S_IDLE;
          end else if (sts.slot_empty) begin
            // empty home slot: take it in place
            cmd.wr         = chtt_pkg::WR_UPD;
            cmd.finish     = 1'b1;
            cmd.fin_status = chtt_pkg::ST_ADDED;
            cmd.fin_add    = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.rd        = chtt_pkg::RD_PROBE;
            cmd.save_prev = 1'b1;
            state_next    = S_PROBE;
          end
        end else begin
          cmd.rd = chtt_pkg::RD_CHAIN;
        end
      end
      S_PROBE: begin
        if (sts.slot_empty) begin
          cmd.wr     = chtt_pkg::WR_LINK;
          state_next = S_LINK;
        end else if (sts.probe_full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = chtt_pkg::ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.rd = chtt_pkg::RD_PROBE;
        end
      end
      S_LINK: begin
        cmd.wr         = chtt_pkg::WR_UPD;
        cmd.finish     = 1'b1;
        cmd.fin_status = chtt_pkg::ST_ADDED;
        cmd.fin_add    = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> src/chtt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtt_dp
// Datapath: item register, slot table, walk/probe pointers and result reg.
// ----------------------------------------------------------------------------
module chtt_dp (
  input  logic           clk,
  input  logic           rst,
  input  chtt_pkg::req_t request,
  input  chtt_pkg::cmd_t cmd,
  output chtt_pkg::sts_t sts,
  output logic           done,
  output chtt_pkg::rsp_t response
);

  chtt_pkg::req_t               req;
  logic [chtt_pkg::IDX_W-1:0]   idx;
  logic [chtt_pkg::IDX_W-1:0]   prev;
  logic [chtt_pkg::CNT_W-1:0]   steps;
  chtt_pkg::slot_t              last;
  logic [chtt_pkg::CNT_W-1:0]   count;
  logic [chtt_pkg::IDX_W-1:0]   clr_addr;

  chtt_pkg::slot_t              rdata;
  logic [chtt_pkg::SLOT_W-1:0]  rdata_raw;
  chtt_pkg::slot_t              wdata;
  logic [chtt_pkg::IDX_W-1:0]   waddr;
  logic [chtt_pkg::IDX_W-1:0]   raddr;
  logic                         we;
  logic                         re;
  logic [chtt_pkg::IDX_W-1:0]   idx_inc;
  logic [chtt_pkg::IDX_W-1:0]   home;
  logic [chtt_pkg::CNT_W-1:0]   count_next;
  logic                         is_set;

  assign rdata   = chtt_pkg::slot_t'(rdata_raw);
  assign is_set  = (req.operation == chtt_pkg::OP_SET);
  assign home    = chtt_pkg::IDX_W'(req.bucket % chtt_pkg::TABLE_SIZE);
  assign idx_inc = (idx == chtt_pkg::IDX_W'(chtt_pkg::TABLE_SIZE - 1)) ?
                   '0 : idx + chtt_pkg::IDX_W'(1);

  // status to the sequencer
  always_comb begin
    sts.key_zero   = (req.key_pc == '0);
    sts.op         = req.operation;
    sts.susp       = req.threads_suspended;
    sts.match      = (rdata.key == req.key_pc);
    sts.at_end     = (rdata.next >= chtt_pkg::CNT_W'(chtt_pkg::TABLE_SIZE)) ||
                     (steps >= chtt_pkg::CNT_W'(chtt_pkg::TABLE_SIZE));
    sts.slot_empty = (rdata.key == '0);
    sts.probe_full = (idx_inc == prev);
    sts.clr_last   = (clr_addr == chtt_pkg::IDX_W'(chtt_pkg::TABLE_SIZE - 1));
  end

  // table port selection
  always_comb begin
    re    = (cmd.rd != chtt_pkg::RD_NONE);
    raddr = idx_inc;
    case (cmd.rd)
      chtt_pkg::RD_HOME:  raddr = home;
      chtt_pkg::RD_CHAIN: raddr = rdata.next[chtt_pkg::IDX_W-1:0];
      chtt_pkg::RD_PROBE: raddr = idx_inc;
      default:            raddr = idx_inc;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    case (cmd.wr)
      chtt_pkg::WR_CLEAR: begin
        we         = 1'b1;
        waddr      = clr_addr;
        wdata      = '0;
        wdata.next = chtt_pkg::CNT_W'(chtt_pkg::TABLE_SIZE);
      end
      chtt_pkg::WR_UPD: begin
        // key in place; code and tag only on a set
        we         = 1'b1;
        waddr      = idx;
        wdata      = rdata;
        wdata.key  = req.key_pc;
        if (is_set) begin
          wdata.code = req.new_code_address;
          wdata.isa  = req.new_isa_tag;
        end
      end
      chtt_pkg::WR_LINK: begin
        we         = 1'b1;
        waddr      = prev;
        wdata      = last;
        wdata.next = {1'b0, idx};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  chtt_ram #(
    .WIDTH (chtt_pkg::SLOT_W),
    .DEPTH (chtt_pkg::TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign count_next = count + chtt_pkg::CNT_W'(cmd.fin_add);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + chtt_pkg::IDX_W'(1);
      end
      if (cmd.finish) begin
        count <= count_next;
      end
      done <= cmd.finish;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    case (cmd.rd)
      chtt_pkg::RD_HOME: begin
        idx   <= home;
        steps <= '0;
      end
      chtt_pkg::RD_CHAIN: begin
        idx   <= rdata.next[chtt_pkg::IDX_W-1:0];
        steps <= steps + chtt_pkg::CNT_W'(1);
      end
      chtt_pkg::RD_PROBE: begin
        idx <= idx_inc;
      end
      default: begin
        idx <= idx;
      end
    endcase
    if (cmd.save_prev) begin
      prev <= idx;
      last <= rdata;
    end
    if (cmd.finish) begin
      response.status     <= cmd.fin_status;
      response.used_count <= count_next;
      if (cmd.fin_status == chtt_pkg::ST_FOUND || cmd.fin_status == chtt_pkg::ST_ADDED) begin
        response.slot_index   <= idx;
        response.code_address <= is_set ? req.new_code_address : rdata.code;
        response.isa_tag      <= is_set ? req.new_isa_tag : rdata.isa;
      end else begin
        response.slot_index   <= '0;
        response.code_address <= '0;
        response.isa_tag      <= '0;
      end
    end
  end

endmodule

>>> src/coalesced_hash_translation_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalesced_hash_translation_table_top
// Coalesced-chaining table mapping bytecode addresses to translated code.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive request and raise start; the item is taken at a
//   rising edge where start is high and busy is low. Fields: operation
//   (lookup, lookup-and-add, set code), nonzero key, precomputed bucket,
//   code address and tag for set, and the suspend flag for lookups.
//   Response channel: done is high for exactly one cycle with response
//   valid; there is no backpressure, the receiver must take it then.
//   Steps: one slot is read per cycle from a slot table with one read port
//   and one write port. An item that hits its home slot goes through accept,
//   decode and walk (done rises in the cycle busy drops); each further chain
//   link adds a walk step, each linear probe a probe step, and linking a new
//   slot onto a chain a link step. Items with a zero key, an unused operation
//   or a suspended lookup finish straight from decode. The table full case
//   sweeps the probe over every other slot before it reports full.
//   Reset: after rst the block runs a clearing pass over all 1024 slots,
//   one slot a cycle, with busy high; items are taken once it completes.
//   One item is in flight at a time.
// ----------------------------------------------------------------------------
module coalesced_hash_translation_table_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  chtt_pkg::req_t request,
  output logic           done,
  output chtt_pkg::rsp_t response
);

  chtt_pkg::cmd_t cmd;
  chtt_pkg::sts_t sts;

  chtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  chtt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .response (response)
  );

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // results never come back to back: each item needs at least decode
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // slot fields are blank unless the key was found or added
  a_blank_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !(response.status == chtt_pkg::ST_FOUND ||
               response.status == chtt_pkg::ST_ADDED)) |->
    (response.slot_index == '0 && response.code_address == '0 &&
     response.isa_tag == '0))
    else $error("miss result carries slot data");

  // an added key means at least one slot is occupied
  a_added_count: assert property (@(posedge clk) disable iff (rst)
    (done && response.status == chtt_pkg::ST_ADDED) |->
    (response.used_count != '0 &&
     response.used_count <= chtt_pkg::CNT_W'(chtt_pkg::TABLE_SIZE)))
    else $error("occupied count out of range after add");

endmodule
